// File: hdl/rfrs_pkg.sv
`default_nettype none

package rfrs_pkg;

   // default geometry of the ring
   localparam int FRAME_BYTES_DEF = 128;
   localparam int SLOT_COUNT_DEF  = 4;

   // operation codes
   localparam logic [2:0] OP_RX_BYTE    = 3'd0;
   localparam logic [2:0] OP_RX_TIMEOUT = 3'd1;
   localparam logic [2:0] OP_READ_BYTE  = 3'd2;
   localparam logic [2:0] OP_SET_READ   = 3'd3;
   localparam logic [2:0] OP_SET_WRITE  = 3'd4;
   localparam logic [2:0] OP_CLR_OVFL   = 3'd5;
   // spare codes, no effect on the ring
   localparam logic [2:0] OP_SPARE_6    = 3'd6;
   localparam logic [2:0] OP_SPARE_7    = 3'd7;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] rx_byte;
      logic [1:0] slot;
      logic [6:0] byte_index;
   } rfrs_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       frame_committed;
      logic [7:0] commit_len;
      logic       overflow;
      logic [1:0] write_pointer;
      logic [1:0] read_pointer;
   } rfrs_rsp_type;

   // everything of a result except the store byte, which comes from the store read port
   typedef struct packed {
      logic       is_read;
      logic       frame_committed;
      logic [7:0] commit_len;
      logic       overflow;
      logic [1:0] write_pointer;
      logic [1:0] read_pointer;
   } rfrs_stage_type;

endpackage

`default_nettype wire

// File: hdl/rfrs_req_if.sv
`default_nettype none

interface rfrs_req_if;
   logic                   valid;
   logic                   ready;
   rfrs_pkg::rfrs_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rfrs_rsp_if.sv
`default_nettype none

interface rfrs_rsp_if;
   logic                   valid;
   logic                   ready;
   rfrs_pkg::rfrs_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/rfrs_ram.sv
`default_nettype none

// simple dual port RAM, registered read that holds while rd_en is low
module rfrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/received_frame_ring_store.sv
`default_nettype none

// Ring of SLOT_COUNT frame buffers of FRAME_BYTES bytes each for received
// radio bytes.
// req_ch: one beat per operation (rx byte, rx timeout, read byte, set read
//   slot, set write slot, clear overflow). rsp_ch: exactly one beat per
//   request beat, in order, with the read byte, the commit flag and length,
//   and the overflow flag and both slot pointers after the operation.
// Pipeline: an accepted request passes the stage register, then the output
//   register (the store read port is registered). Throughput: one beat per
//   cycle unless rsp_ch stalls. Pointer and position updates are done in
//   the accept cycle, so back-to-back operations see each other's effects.
// Stall: a response waiting on rsp_ch does not block; one more request is
//   taken while its store read sits in the stage register. req_ch.ready
//   drops only when both the stage and the output register are full.
// Reset: pointers, overflow flag and byte position clear to zero, pipeline
//   empties. The store itself is not cleared; reading a byte never written
//   returns an undefined value.
module received_frame_ring_store #(
   parameter int FRAME_BYTES = rfrs_pkg::FRAME_BYTES_DEF,
   parameter int SLOT_COUNT  = rfrs_pkg::SLOT_COUNT_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rfrs_req_if.sink  req_ch,
   rfrs_rsp_if.source rsp_ch
);

   localparam int SW    = $clog2(SLOT_COUNT);
   localparam int PW    = $clog2(FRAME_BYTES);
   localparam int DEPTH = SLOT_COUNT * FRAME_BYTES;
   localparam int AW    = $clog2(DEPTH);

   // architectural state
   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] read_slot_ff, read_slot_in;
   logic          overflow_flag_ff, overflow_flag_in;
   logic [PW-1:0] byte_pos_ff, byte_pos_in;

   // pipeline: stage waits on the store read, rsp is the output register
   logic                     s1_valid_ff, s1_valid_in;
   rfrs_pkg::rfrs_stage_type s1_ff, s1_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rfrs_pkg::rfrs_rsp_type   rsp_ff, rsp_in;

   logic                     s1_adv;
   logic                     accept;

   // store port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // decode helpers
   logic [SW-1:0] req_slot;
   logic          slot_ok;
   logic          idx_ok;
   logic          pos_last;
   logic          frame_done;
   logic          commit;
   logic [7:0]    length;
   logic [SW-1:0] write_next;
   logic [SW-1:0] read_next;

   rfrs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.data.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake: stage moves on whenever the output register is free
   assign s1_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   assign req_slot = SW'(req_ch.data.slot);
   assign slot_ok  = 32'(req_ch.data.slot) < 32'(SLOT_COUNT);
   assign idx_ok   = 32'(req_ch.data.byte_index) < 32'(FRAME_BYTES);
   assign pos_last = byte_pos_ff == PW'(FRAME_BYTES - 1);

   assign write_next = (write_slot_ff == SW'(SLOT_COUNT - 1)) ? '0 : write_slot_ff + 1'b1;
   assign read_next  = (read_slot_ff == SW'(SLOT_COUNT - 1)) ? '0 : read_slot_ff + 1'b1;

   // a frame ends on a zero byte or on the last byte of the slot
   assign frame_done = (req_ch.data.rx_byte == 8'd0) || pos_last;
   assign length     = (req_ch.data.rx_byte == 8'd0) ? 8'(byte_pos_ff) : 8'(FRAME_BYTES);
   // an empty frame (zero byte at position zero) is not committed
   assign commit     = (req_ch.data.operation == rfrs_pkg::OP_RX_BYTE) && frame_done &&
                       !((req_ch.data.rx_byte == 8'd0) && (byte_pos_ff == '0));

   // every rx byte is stored at the current position of the write slot
   assign wr_en   = accept && (req_ch.data.operation == rfrs_pkg::OP_RX_BYTE);
   assign wr_addr = AW'(write_slot_ff) * AW'(FRAME_BYTES) + AW'(byte_pos_ff);
   assign rd_en   = accept && (req_ch.data.operation == rfrs_pkg::OP_READ_BYTE);
   assign rd_addr = AW'(req_slot) * AW'(FRAME_BYTES) + AW'(req_ch.data.byte_index);

   always_comb begin
      write_slot_in    = write_slot_ff;
      read_slot_in     = read_slot_ff;
      overflow_flag_in = overflow_flag_ff;
      byte_pos_in      = byte_pos_ff;

      unique case (req_ch.data.operation)
         rfrs_pkg::OP_RX_BYTE: begin
            byte_pos_in = frame_done ? '0 : byte_pos_ff + 1'b1;
            if (commit) begin
               write_slot_in = write_next;
               // ring full and already flagged: drop the oldest frame
               if ((write_slot_ff == read_slot_ff) && overflow_flag_ff) begin
                  read_slot_in = read_next;
               end else if (write_next == read_slot_ff) begin
                  overflow_flag_in = 1'b1;
               end
            end
         end
         rfrs_pkg::OP_RX_TIMEOUT: begin
            byte_pos_in = '0;
         end
         rfrs_pkg::OP_SET_READ: begin
            if (slot_ok) begin
               read_slot_in = req_slot;
            end
         end
         rfrs_pkg::OP_SET_WRITE: begin
            if (slot_ok) begin
               write_slot_in = req_slot;
            end
            byte_pos_in = '0;
         end
         rfrs_pkg::OP_CLR_OVFL: begin
            overflow_flag_in = 1'b0;
         end
         default: begin
         end
      endcase

      s1_in.is_read         = (req_ch.data.operation == rfrs_pkg::OP_READ_BYTE) &&
                              slot_ok && idx_ok;
      s1_in.frame_committed = commit;
      s1_in.commit_len      = commit ? length : 8'd0;
      s1_in.overflow        = overflow_flag_in;
      s1_in.write_pointer   = 2'(write_slot_in);
      s1_in.read_pointer    = 2'(read_slot_in);

      s1_valid_in = req_ch.ready ? accept : s1_valid_ff;

      rsp_in.read_data       = s1_ff.is_read ? rd_data : 8'd0;
      rsp_in.frame_committed = s1_ff.frame_committed;
      rsp_in.commit_len      = s1_ff.commit_len;
      rsp_in.overflow        = s1_ff.overflow;
      rsp_in.write_pointer   = s1_ff.write_pointer;
      rsp_in.read_pointer    = s1_ff.read_pointer;

      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff    <= '0;
         read_slot_ff     <= '0;
         overflow_flag_ff <= 1'b0;
         byte_pos_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            write_slot_ff    <= write_slot_in;
            read_slot_ff     <= read_slot_in;
            overflow_flag_ff <= overflow_flag_in;
            byte_pos_ff      <= byte_pos_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

`ifndef SYNTH
   // byte position never runs past the end of a slot
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(byte_pos_ff) < 32'(FRAME_BYTES))
      else $error("byte position out of slot");

   // the overflow flag is only raised when write catches up with read
   a_ovfl_set: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_flag_ff) |-> (write_slot_ff == read_slot_ff))
      else $error("overflow raised with write and read apart");

   // a committed frame always carries a length, except a full 256-byte slot
   a_commit_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_committed) |->
         ((rsp_ff.commit_len != 8'd0) || (FRAME_BYTES == 256)))
      else $error("committed frame with zero length");

   // no request taken while the stage is stuck behind a full output
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ch.ready) |=> $stable(s1_ff))
      else $error("stage overwritten while stalled");
`endif

endmodule

`default_nettype wire
